// ===== rtl/core/kslru_pkg.sv =====
// Shared types and constants for the keyed signal-strength LRU cache.
package kslru_pkg;

  // Default number of cache slots
  localparam int ENTRIES_DEF = 32;

  // Field widths
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 16;
  localparam int STAMP_W = 32;
  localparam int STS_W   = 3;

  // Operation codes carried on in_tuser
  localparam logic OP_SET = 1'b0;
  localparam logic OP_GET = 1'b1;

  // Result status codes carried on out_tuser
  typedef enum logic [STS_W-1:0] {
    ST_UPDATED  = 3'd0,
    ST_INSERTED = 3'd1,
    ST_REPLACED = 3'd2,
    ST_IGNORED  = 3'd3,
    ST_HIT      = 3'd4,
    ST_MISS     = 3'd5
  } status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;     // capture the request
    logic scan_rd;  // read the slot at the scan pointer and advance
    logic finish;   // commit the store update and load the result register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic skip_scan;  // request needs no pass over the slots
    logic scan_last;  // scan pointer is at the last filled slot
    logic out_free;   // result register can take a new result
  } sts_t;

endpackage

// ===== rtl/core/kslru_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module kslru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/kslru_datapath.sv =====
// Datapath: request registers, slot store, scan compare, counters and result register.
module kslru_datapath #(
  parameter int ENTRIES = kslru_pkg::ENTRIES_DEF
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  kslru_pkg::cmd_t                                  cmd_i,
  output kslru_pkg::sts_t                                  sts_o,
  // in_tdata: node_id [31:0], rssi_in [47:32]
  input  logic [kslru_pkg::KEY_W+kslru_pkg::VAL_W-1:0]     in_tdata,
  // in_tuser: operation [0]
  input  logic                                             in_tuser,
  output logic                                             out_tvalid,
  input  logic                                             out_tready,
  // out_tdata: rssi_out [15:0]
  output logic [kslru_pkg::VAL_W-1:0]                      out_tdata,
  // out_tuser: status [2:0]
  output logic [kslru_pkg::STS_W-1:0]                      out_tuser
);

  import kslru_pkg::*;

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int WORD_W = KEY_W + VAL_W + STAMP_W;

  // request
  logic                    req_op_r;
  logic [KEY_W-1:0]        req_node_r;
  logic signed [VAL_W-1:0] req_rssi_r;

  // store bookkeeping
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic [STAMP_W-1:0] use_cnt_r, use_cnt_nxt;

  // scan
  logic [CNT_W-1:0]        scan_idx_r;
  logic                    cmp_vld_r;
  logic [IDX_W-1:0]        cmp_idx_r;
  logic                    match_r;
  logic [IDX_W-1:0]        match_idx_r;
  logic signed [VAL_W-1:0] match_val_r;
  logic [IDX_W-1:0]        min_idx_r;
  logic [STAMP_W-1:0]      min_stamp_r;

  // result
  logic                    out_valid_r;
  logic signed [VAL_W-1:0] out_rssi_r;
  status_t                 out_status_r;

  // RAM interface
  logic [WORD_W-1:0]  rd_word;
  logic [WORD_W-1:0]  wr_word;
  logic               wr_en;
  logic [KEY_W-1:0]   rd_key;
  logic [VAL_W-1:0]   rd_val;
  logic [STAMP_W-1:0] rd_stamp;

  // decision
  logic                    is_get;
  logic                    set_ignored;
  logic                    has_room;
  logic                    do_write;
  logic                    fill_inc;
  logic [IDX_W-1:0]        slot;
  status_t                 res_status;
  logic signed [VAL_W-1:0] res_rssi;

  // slot word layout: {stamp, value, key}
  assign rd_key   = rd_word[KEY_W-1:0];
  assign rd_val   = rd_word[KEY_W +: VAL_W];
  assign rd_stamp = rd_word[KEY_W+VAL_W +: STAMP_W];

  // request classification
  assign is_get      = (req_op_r == OP_GET);
  assign set_ignored = !is_get && ((req_node_r == '0) || (req_rssi_r == '0));
  assign has_room    = (fill_r < CNT_W'(ENTRIES));

  assign sts_o.skip_scan = (is_get && (req_node_r == '0)) || set_ignored || (fill_r == '0);
  assign sts_o.scan_last = ((scan_idx_r + CNT_W'(1)) == fill_r);
  assign sts_o.out_free  = !out_valid_r || out_tready;

  // outcome once the scan is complete
  always_comb begin
    res_status = ST_MISS;
    res_rssi   = '0;
    do_write   = 1'b0;
    fill_inc   = 1'b0;
    slot       = match_idx_r;
    if (is_get) begin
      if (match_r) begin
        res_status = ST_HIT;
        res_rssi   = match_val_r;
      end
    end else if (set_ignored) begin
      res_status = ST_IGNORED;
    end else begin
      do_write = 1'b1;
      if (match_r) begin
        res_status = ST_UPDATED;
      end else if (has_room) begin
        res_status = ST_INSERTED;
        slot       = fill_r[IDX_W-1:0];
        fill_inc   = 1'b1;
      end else begin
        res_status = ST_REPLACED;
        slot       = min_idx_r;
      end
    end
  end

  assign wr_en       = cmd_i.finish && do_write;
  assign use_cnt_nxt = use_cnt_r + STAMP_W'(1);
  assign fill_nxt    = fill_r + CNT_W'(1);
  assign wr_word     = {use_cnt_nxt, req_rssi_r, req_node_r};

  kslru_ram #(
    .WIDTH(WORD_W),
    .DEPTH(ENTRIES)
  ) u_store (
    .clk  (clk),
    .we   (wr_en),
    .waddr(slot),
    .wdata(wr_word),
    .re   (cmd_i.scan_rd),
    .raddr(scan_idx_r[IDX_W-1:0]),
    .rdata(rd_word)
  );

  // request capture
  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      req_op_r   <= in_tuser;
      req_node_r <= in_tdata[KEY_W-1:0];
      req_rssi_r <= in_tdata[KEY_W +: VAL_W];
    end
  end

  // scan pointer and read tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_vld_r  <= 1'b0;
      scan_idx_r <= '0;
    end else begin
      cmp_vld_r <= cmd_i.scan_rd;
      if (cmd_i.load) begin
        scan_idx_r <= '0;
      end else if (cmd_i.scan_rd) begin
        scan_idx_r <= scan_idx_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.scan_rd) begin
      cmp_idx_r <= scan_idx_r[IDX_W-1:0];
    end
  end

  // key match and oldest-stamp search, one slot per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else if (cmd_i.load) begin
      match_r <= 1'b0;
    end else if (cmp_vld_r && !match_r && (rd_key == req_node_r)) begin
      match_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_vld_r) begin
      if (!match_r && (rd_key == req_node_r)) begin
        match_idx_r <= cmp_idx_r;
        match_val_r <= rd_val;
      end
      // strict compare keeps the lowest index on equal stamps
      if ((cmp_idx_r == '0) || (rd_stamp < min_stamp_r)) begin
        min_idx_r   <= cmp_idx_r;
        min_stamp_r <= rd_stamp;
      end
    end
  end

  // fill count and use counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      use_cnt_r <= '0;
    end else if (wr_en) begin
      use_cnt_r <= use_cnt_nxt;
      if (fill_inc) begin
        fill_r <= fill_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.finish) begin
      out_rssi_r   <= res_rssi;
      out_status_r <= res_status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_rssi_r;
  assign out_tuser  = out_status_r;

  // fill count never passes the slot count
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(ENTRIES))
    else $error("fill count exceeds slot count");

  // use counter moves only with a committed write
  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !wr_en |=> use_cnt_r == $past(use_cnt_r))
    else $error("use counter changed without a store write");

  // a new result appears only on a finish command
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd_i.finish))
    else $error("result valid without finish");

endmodule

// ===== rtl/core/kslru_ctrl.sv =====
// Controller state machine: request accept, slot scan sequencing, commit.
module kslru_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  kslru_pkg::sts_t sts_i,
  output kslru_pkg::cmd_t cmd_o
);

  import kslru_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_SCAN  = 5'b00100,
    S_DRAIN = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd_o.load    = 1'b0;
    cmd_o.scan_rd = 1'b0;
    cmd_o.finish  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_o.load = 1'b1;
          state_nxt  = S_CHECK;
        end
      end
      S_CHECK: begin
        state_nxt = sts_i.skip_scan ? S_DONE : S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last read word is compared in this cycle
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // commit never overwrites a result still waiting at the output
  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.finish |-> sts_i.out_free)
    else $error("commit while result register busy");

  // one request at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.load |=> !in_tready)
    else $error("ready held after accept");

  // exactly one state bit set
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("state register not one-hot");

endmodule

// ===== rtl/core/keyed_signal_cache_lru_core.sv =====
// Top level of the keyed signal-strength cache with least-recently-set replacement.
// Flow: accept, check, scan over the F filled slots, drain, then commit to the result register;
//   ignored sets, gets of node 0 and an empty store skip the scan and the drain.
// One request is handled at a time; the scan reads the single-read-port slot RAM one entry per
//   cycle. A held result adds stalls.
// Reset (synchronous, active low) empties the store at once by clearing the fill count;
//   no clearing pass is run. Use counter, state machine and result valid also clear.
module keyed_signal_cache_lru_core #(
  parameter int ENTRIES = kslru_pkg::ENTRIES_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         in_tvalid,
  output logic                                         in_tready,
  // in_tdata: node_id [31:0], rssi_in [47:32]
  input  logic [kslru_pkg::KEY_W+kslru_pkg::VAL_W-1:0] in_tdata,
  // in_tuser: operation [0]
  input  logic                                         in_tuser,
  output logic                                         out_tvalid,
  input  logic                                         out_tready,
  // out_tdata: rssi_out [15:0]
  output logic [kslru_pkg::VAL_W-1:0]                  out_tdata,
  // out_tuser: status [2:0]
  output logic [kslru_pkg::STS_W-1:0]                  out_tuser
);

  import kslru_pkg::*;

  cmd_t cmd;
  sts_t sts;

  kslru_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  kslru_datapath #(
    .ENTRIES(ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule
